/* rtl/dccs_pkg.sv */
package dccs_pkg;

    // field widths
    localparam int IDX_W  = 31;
    localparam int WORD_W = 32;
    localparam int CFG_W  = 11;

    localparam int DEPTH_DEF = 1024;

    localparam logic [CFG_W-1:0]  CFG_RESET  = 11'd1024;
    localparam logic [WORD_W-1:0] COPY0_INIT = 32'h5353_5353;

    // index reduction: dividend padded to DIV_BITS * DIV_STEPS bits
    localparam int DIV_BITS  = 4;
    localparam int DIV_STEPS = 8;
    localparam int DIV_W     = DIV_BITS * DIV_STEPS;

    // operation codes
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_PREP  = 2'd2;
    localparam logic [1:0] OP_DUMP  = 2'd3;

    // per-entry select bits and copy 0, kept in one memory
    typedef struct packed {
        logic              rsel;
        logic              wsel;
        logic [WORD_W-1:0] c0;
    } t_meta;

endpackage

/* rtl/dual_copy_checkpoint_store.sv */
// Two-copy checkpoint word store.
//
// Command channel: a word (i_op, i_index, i_value) is taken at a rising edge
// with start high and busy low. Every command gives exactly one result word
// (o_data, o_copy_used), shown for one cycle with o_strobe high. The receiver
// cannot stall: results are never held, and none is ever dropped.
// Config channel: i_cfg_data is the entry count in use, written at an edge
// with i_cfg_valid and o_cfg_ready high; o_cfg_ready is always high. Write it
// only while the store is idle. 0 acts as 1, values above DEPTH act as DEPTH.
//
// Sequence per command, from the accept edge:
//   read / write / dump, index below the count: the entry is read at
//     the accept edge, then the execute state registers the result (one
//     memory read-modify-write per command); busy is high through it.
//   index at or past the count: a remainder unit takes 4 index bits per
//     cycle over the padded index, then the entry is read, then execute.
//   checkpoint prepare: walks entries 0..count-1 one per cycle with a
//     pipelined read/write-back, then strobes from the walk-end state.
// Reset: the count resets to 1024, then a clearing pass writes all DEPTH entries
// of the select/copy-0 memory (busy high); copy 1 is not cleared.
module dual_copy_checkpoint_store #(
    parameter int DEPTH = dccs_pkg::DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // command channel
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        i_op,
    input  logic [dccs_pkg::IDX_W-1:0]        i_index,
    input  logic signed [dccs_pkg::WORD_W-1:0] i_value,
    // result channel
    output logic                              o_strobe,
    output logic signed [dccs_pkg::WORD_W-1:0] o_data,
    output logic                              o_copy_used,
    // config channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [dccs_pkg::CFG_W-1:0]        i_cfg_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = dccs_pkg::CFG_W;
    localparam int XW = (AW + 1 > NW) ? AW + 1 : NW;
    localparam int WW = dccs_pkg::WORD_W;

    // sequencer states
    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_EXE  = 3'd4;
    localparam logic [2:0] S_WALK = 3'd5;
    localparam logic [2:0] S_WEND = 3'd6;

    localparam logic [2:0] DIV_LAST = 3'(dccs_pkg::DIV_STEPS - 1);

    // storage: select bits + copy 0 (cleared after reset), copy 1 (never cleared)
    dccs_pkg::t_meta   r_mem_a [DEPTH];
    logic [WW-1:0]     r_mem_b [DEPTH];
    dccs_pkg::t_meta   r_a_q;
    logic [WW-1:0]     r_b_q;

    logic [2:0]        r_state;
    logic [NW-1:0]     r_cfg;
    logic [1:0]        r_op;
    logic [WW-1:0]     r_val;
    logic [AW-1:0]     r_addr;
    logic [AW-1:0]     r_cnt;
    logic [AW-1:0]     r_waddr;
    logic              r_wv;
    logic [dccs_pkg::DIV_W-1:0] r_div;
    logic [NW-1:0]     r_rem;
    logic [2:0]        r_step;

    logic              r_strobe;
    logic [WW-1:0]     r_data;
    logic              r_copy;

    logic [NW-1:0]     n_used;
    logic [XW-1:0]     cfg_x;
    logic [NW-1:0]     n_rem;
    logic [XW-1:0]     rem_x;
    logic [AW-1:0]     rd_addr;
    logic              accept;
    logic              direct;
    logic              walk_last;

    // effective entry count: 0 -> 1, above DEPTH -> DEPTH
    always_comb begin
        cfg_x = XW'(r_cfg);
        if (r_cfg == '0) begin
            n_used = NW'(1);
        end else if (cfg_x > XW'(DEPTH)) begin
            n_used = NW'(DEPTH);
        end else begin
            n_used = r_cfg;
        end
    end

    // remainder unit: four restoring steps per cycle
    always_comb begin
        logic [NW-1:0] rem;
        logic [NW:0]   t;
        rem = r_rem;
        t   = '0;
        for (int k = 0; k < dccs_pkg::DIV_BITS; k++) begin
            t = {rem, r_div[dccs_pkg::DIV_W-1-k]};
            if (t >= {1'b0, n_used}) begin
                t = t - {1'b0, n_used};
            end
            rem = t[NW-1:0];
        end
        n_rem = rem;
    end

    assign rem_x     = XW'(n_rem);
    assign accept    = start && !busy;
    assign direct    = (i_index < dccs_pkg::IDX_W'(n_used));
    assign walk_last = (XW'(r_cnt) == XW'(n_used - NW'(1)));

    always_comb begin
        unique case (r_state)
            S_IDLE:  rd_addr = i_index[AW-1:0];
            S_WALK:  rd_addr = r_cnt;
            default: rd_addr = r_addr;
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_cfg    <= dccs_pkg::CFG_RESET;
            r_cnt    <= '0;
            r_wv     <= 1'b0;
            r_step   <= '0;
            r_strobe <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg <= i_cfg_data;
            end
            // result leaves on the edge that ends an execute or walk-end cycle
            r_strobe <= (r_state == S_EXE) || (r_state == S_WEND);
            unique case (r_state)
                S_CLR: begin
                    r_cnt <= r_cnt + AW'(1);
                    if (r_cnt == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_op  <= i_op;
                        r_val <= i_value;
                        if (i_op == dccs_pkg::OP_PREP) begin
                            r_cnt   <= '0;
                            r_wv    <= 1'b0;
                            r_state <= S_WALK;
                        end else if (direct) begin
                            r_addr  <= i_index[AW-1:0];
                            r_state <= S_EXE;
                        end else begin
                            r_div   <= dccs_pkg::DIV_W'(i_index);
                            r_rem   <= '0;
                            r_step  <= '0;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_rem  <= n_rem;
                    r_div  <= r_div << dccs_pkg::DIV_BITS;
                    r_step <= r_step + 3'd1;
                    if (r_step == DIV_LAST) begin
                        r_addr  <= rem_x[AW-1:0];
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_EXE;
                end
                S_EXE: begin
                    r_state  <= S_IDLE;
                    unique case (r_op)
                        dccs_pkg::OP_READ: begin
                            r_copy <= r_a_q.rsel;
                            r_data <= r_a_q.rsel ? r_b_q : r_a_q.c0;
                        end
                        dccs_pkg::OP_WRITE: begin
                            r_copy <= r_a_q.wsel;
                            r_data <= '0;
                        end
                        dccs_pkg::OP_DUMP: begin
                            r_copy <= !r_a_q.wsel;
                            r_data <= r_a_q.wsel ? r_a_q.c0 : r_b_q;
                        end
                        default: begin
                            r_copy <= 1'b0;
                            r_data <= '0;
                        end
                    endcase
                end
                S_WALK: begin
                    r_cnt   <= r_cnt + AW'(1);
                    r_waddr <= r_cnt;
                    r_wv    <= 1'b1;
                    if (walk_last) begin
                        r_state <= S_WEND;
                    end
                end
                S_WEND: begin
                    r_copy   <= 1'b0;
                    r_data   <= '0;
                    r_wv     <= 1'b0;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // memories: one read per cycle at rd_addr, registered
    always_ff @(posedge i_clk) begin
        r_a_q <= r_mem_a[rd_addr];
        r_b_q <= r_mem_b[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CLR) begin
            r_mem_a[r_cnt] <= '{rsel: 1'b0, wsel: 1'b1, c0: dccs_pkg::COPY0_INIT};
        end else if (r_state == S_EXE && r_op == dccs_pkg::OP_WRITE) begin
            if (r_a_q.wsel) begin
                r_mem_a[r_addr] <= '{rsel: 1'b1, wsel: 1'b1, c0: r_a_q.c0};
            end else begin
                r_mem_a[r_addr] <= '{rsel: 1'b0, wsel: 1'b0, c0: r_val};
            end
        end else if ((r_state == S_WALK || r_state == S_WEND) && r_wv) begin
            // prepare: write select becomes the inverse of read select
            r_mem_a[r_waddr] <= '{rsel: r_a_q.rsel, wsel: !r_a_q.rsel, c0: r_a_q.c0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EXE && r_op == dccs_pkg::OP_WRITE && r_a_q.wsel) begin
            r_mem_b[r_addr] <= r_val;
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_strobe    = r_strobe;
    assign o_data      = r_data;
    assign o_copy_used = r_copy;

    // checks
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |=> !r_strobe)
        else $error("result strobe on two consecutive cycles");

    a_direct_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && direct && i_op != dccs_pkg::OP_PREP) |=> ##1 r_strobe)
        else $error("in-range command did not finish in two cycles");

    a_strobe_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> ($past(r_state) == S_EXE || $past(r_state) == S_WEND))
        else $error("result strobe from wrong state");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_step == DIV_LAST) |=> (r_rem < n_used))
        else $error("reduced index not below entry count");

endmodule

/* sim/dccs_checker.sv */
module dccs_checker #(
    parameter int DEPTH = dccs_pkg::DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic [1:0]                  i_op,
    input  logic [dccs_pkg::IDX_W-1:0]  i_index,
    input  logic [dccs_pkg::WORD_W-1:0] i_value,
    input  logic                        o_strobe,
    input  logic [dccs_pkg::WORD_W-1:0] o_data,
    input  logic                        o_copy_used,
    input  logic                        i_cfg_valid,
    input  logic                        o_cfg_ready,
    input  logic [dccs_pkg::CFG_W-1:0]  i_cfg_data,
    output int                          waiting,
    output int                          mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [dccs_pkg::WORD_W-1:0] data;
        logic                        copy_used;
    } t_result;

    // shadow copy of the store
    logic [dccs_pkg::WORD_W-1:0] copy0 [DEPTH];
    logic [dccs_pkg::WORD_W-1:0] copy1 [DEPTH];
    logic                        rsel  [DEPTH];
    logic                        wsel  [DEPTH];
    logic [dccs_pkg::CFG_W-1:0]  entry_count;

    t_result expected_words [$];

    initial begin
        waiting    = 0;
        mismatches = 0;
    end

    // Applies one command to the shadow store and returns the word it answers with.
    function automatic t_result apply_command(logic [1:0] op,
                                              logic [dccs_pkg::IDX_W-1:0] idx,
                                              logic [dccs_pkg::WORD_W-1:0] val);
        int unsigned n;
        int unsigned e;
        t_result     r;
        n = (entry_count == 0) ? 1 : ((entry_count > DEPTH) ? DEPTH : entry_count);
        e = (idx >= n) ? idx % n : idx;
        r = '0;
        case (op)
            dccs_pkg::OP_READ: begin
                r.copy_used = rsel[e];
                r.data      = rsel[e] ? copy1[e] : copy0[e];
            end
            dccs_pkg::OP_WRITE: begin
                r.copy_used = wsel[e];
                if (wsel[e]) copy1[e] = val;
                else         copy0[e] = val;
                rsel[e] = wsel[e];
            end
            dccs_pkg::OP_PREP: begin
                for (int i = 0; i < n; i++) wsel[i] = ~rsel[i];
            end
            default: begin
                // dump: the stable copy, the one wsel does not name
                r.copy_used = ~wsel[e];
                r.data      = wsel[e] ? copy0[e] : copy1[e];
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                copy0[i] = dccs_pkg::COPY0_INIT;
                copy1[i] = '0;
                rsel[i]  = 1'b0;
                wsel[i]  = 1'b1;
            end
            entry_count = dccs_pkg::CFG_RESET;
            expected_words.delete();
        end else begin
            if (o_strobe) begin
                if (expected_words.size() == 0) begin
                    $error("result word with none expected: data %h copy_used %0d",
                           o_data, o_copy_used);
                    mismatches++;
                end else begin
                    want = expected_words.pop_front();
                    if (o_data !== want.data) begin
                        $error("data: expected %h, actual %h", want.data, o_data);
                        mismatches++;
                    end
                    if (o_copy_used !== want.copy_used) begin
                        $error("copy_used: expected %0d, actual %0d",
                               want.copy_used, o_copy_used);
                        mismatches++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) entry_count = i_cfg_data;
            if (start && !busy) expected_words.push_back(apply_command(i_op, i_index, i_value));
        end
        waiting <= expected_words.size();
    end

endmodule

/* sim/tb_dual_copy_checkpoint_store.sv */
module tb_dual_copy_checkpoint_store;
    timeunit 1ns;
    timeprecision 1ps;

    // longest stretch with no handshake at all: a prepare over 1024 entries
    // or the clearing pass after reset
    localparam int STALL_LIMIT = 5000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 100;

    logic                               i_clk;
    logic                               i_rst_n     = 1'b0;
    logic                               start       = 1'b0;
    logic                               busy;
    logic [1:0]                         i_op        = dccs_pkg::OP_READ;
    logic [dccs_pkg::IDX_W-1:0]         i_index     = '0;
    logic signed [dccs_pkg::WORD_W-1:0] i_value     = '0;
    logic                               o_strobe;
    logic signed [dccs_pkg::WORD_W-1:0] o_data;
    logic                               o_copy_used;
    logic                               i_cfg_valid = 1'b0;
    logic                               o_cfg_ready;
    logic [dccs_pkg::CFG_W-1:0]         i_cfg_data  = '0;

    int          waiting;
    int          mismatches;
    int          idle_cycles = 0;
    int unsigned live_entries = dccs_pkg::DEPTH_DEF;   // count the store acts on
    int unsigned gap_pct = 0;                // chance of a sender gap per word

    // entry count and sender idling per random phase; 1025 and 2047 hit the upper clamp
    int unsigned phase_count [PHASES] = '{3, 1, 1024, 17, 2047, 64, 2, 1025};
    int unsigned phase_gap   [PHASES] = '{0, 50, 0, 29, 50, 0, 29, 0};

    dual_copy_checkpoint_store #(.DEPTH(dccs_pkg::DEPTH_DEF)) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_op        (i_op),
        .i_index     (i_index),
        .i_value     (i_value),
        .o_strobe    (o_strobe),
        .o_data      (o_data),
        .o_copy_used (o_copy_used),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    dccs_checker #(.DEPTH(dccs_pkg::DEPTH_DEF)) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_op        (i_op),
        .i_index     (i_index),
        .i_value     (i_value),
        .o_strobe    (o_strobe),
        .o_data      (o_data),
        .o_copy_used (o_copy_used),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .waiting     (waiting),
        .mismatches  (mismatches)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Present one command word and hold it until the edge that takes it.
    // start stays high afterwards; only a random gap here or a drain lowers it.
    task automatic issue(logic [1:0] op, logic [dccs_pkg::IDX_W-1:0] idx,
                         logic [dccs_pkg::WORD_W-1:0] val);
        start   <= 1'b1;
        i_op    <= op;
        i_index <= idx;
        i_value <= val;
        do @(posedge i_clk); while (busy);
        if ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
    endtask

    // Sender holds off until the store is quiet and every result is back.
    task automatic drain;
        start <= 1'b0;
        @(posedge i_clk);
        while (waiting != 0 || busy) @(posedge i_clk);
    endtask

    // Count register write; only called after drain.
    task automatic set_entries(logic [dccs_pkg::CFG_W-1:0] cnt);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cnt;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        live_entries = (cnt == 0) ? 1 :
                       ((cnt > dccs_pkg::DEPTH_DEF) ? dccs_pkg::DEPTH_DEF : cnt);
    endtask

    // Mostly in range, some anywhere below 2048, a few anywhere in 31 bits.
    function automatic logic [dccs_pkg::IDX_W-1:0] pick_index();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70) return dccs_pkg::IDX_W'($urandom_range(live_entries - 1, 0));
        if (r < 90) return dccs_pkg::IDX_W'($urandom_range(2047, 0));
        return dccs_pkg::IDX_W'($urandom() & 32'h7FFF_FFFF);
    endfunction

    function automatic logic [dccs_pkg::WORD_W-1:0] pick_value();
        case ($urandom_range(19))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h8000_0000;
            default: return $urandom();
        endcase
    endfunction

    initial begin : stimulus
        int unsigned r;
        int unsigned prep_pct;
        logic [1:0]  op;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        drain();    // rides out the clearing pass

        // ---- directed: full count, copy 0 preset pattern visible first
        issue(dccs_pkg::OP_READ,  31'd0,         32'h0);
        issue(dccs_pkg::OP_DUMP,  31'd1023,      32'h0);
        issue(dccs_pkg::OP_WRITE, 31'd0,         32'h7FFF_FFFF);  // wsel=1 at reset: copy 1
        issue(dccs_pkg::OP_READ,  31'd0,         32'h0);
        issue(dccs_pkg::OP_WRITE, 31'd1023,      32'h8000_0000);
        issue(dccs_pkg::OP_READ,  31'd1023,      32'hFFFF_FFFF);
        issue(dccs_pkg::OP_WRITE, 31'h7FFF_FFFF, 32'hFFFF_FFFF);  // max index folds to 1023
        issue(dccs_pkg::OP_READ,  31'd1024,      32'h0);          // index == count folds to 0
        issue(dccs_pkg::OP_DUMP,  31'd0,         32'h0);          // stable copy still copy 0
        issue(dccs_pkg::OP_PREP,  31'h7FFF_FFFF, 32'hFFFF_FFFF);  // index and value ignored
        issue(dccs_pkg::OP_DUMP,  31'd0,         32'h0);          // now copy 1 is stable
        issue(dccs_pkg::OP_WRITE, 31'd0,         32'h0000_0000);  // lands in copy 0
        issue(dccs_pkg::OP_READ,  31'd0,         32'h0);
        issue(dccs_pkg::OP_DUMP,  31'd0,         32'h0);
        issue(dccs_pkg::OP_READ,  31'h4000_0000, 32'h0);
        issue(dccs_pkg::OP_WRITE, 31'd5,         32'h0000_0001);
        issue(dccs_pkg::OP_READ,  31'd5,         32'h0);

        // count of zero acts as one entry: every index lands on entry 0
        drain();
        set_entries(11'd0);
        issue(dccs_pkg::OP_READ,  31'd12345,     32'h0);
        issue(dccs_pkg::OP_WRITE, 31'd77,        32'h1234_5678);
        issue(dccs_pkg::OP_PREP,  31'd0,         32'h0);
        issue(dccs_pkg::OP_DUMP,  31'd999,       32'h0);

        // count above the depth acts as the full depth; entries past the
        // old count kept their contents
        drain();
        set_entries(11'd2047);
        issue(dccs_pkg::OP_READ,  31'd1500,      32'h0);
        issue(dccs_pkg::OP_DUMP,  31'd1023,      32'h0);

        // ---- random phases, each at its own count and idling mix
        for (int p = 0; p < PHASES; p++) begin
            drain();
            gap_pct = 0;
            set_entries(phase_count[p][dccs_pkg::CFG_W-1:0]);
            gap_pct  = phase_gap[p];
            // prepare walks the whole count: keep it rare when the count is big
            prep_pct = (live_entries <= 64) ? 8 : 1;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                r = $urandom_range(99);
                if (r < prep_pct)      op = dccs_pkg::OP_PREP;
                else if (r < 40)       op = dccs_pkg::OP_WRITE;
                else if (r < 70)       op = dccs_pkg::OP_READ;
                else                   op = dccs_pkg::OP_DUMP;
                issue(op, pick_index(), pick_value());
            end
        end

        // ---- wind down
        drain();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && waiting == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
